// ===== sv/mets_pkg.sv =====
// shared types, constants and the quarter-wave sine table of the missing et sum
package mets_pkg;

    localparam int MAX_CLUSTERS = 1024;
    localparam int PHI_BITS     = 10;
    localparam int ET_BITS      = 16;

    localparam int IN_ET_W  = 16;
    localparam int IN_PHI_W = 10;
    localparam int EX_W     = 27;
    localparam int ET_OUT_W = 26;
    localparam int SUM_W    = 28;
    localparam int ET_SUM_W = 27;

    localparam int TRIG_W   = 15;
    localparam int TRIG_ONE = 16384;
    localparam int FRAC_W   = 14;
    localparam int J_W      = PHI_BITS - 2;
    localparam int QTR      = 1 << J_W;
    localparam int TAB_AW   = J_W + 1;
    localparam int PROD_W   = ET_BITS + TRIG_W;
    localparam int MAG_W    = PROD_W - FRAC_W;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    localparam logic signed [SUM_W-1:0] SUM_LIMIT =
        SUM_W'(MAX_CLUSTERS * ((1 << ET_BITS) - 1));
    localparam logic signed [SUM_W-1:0] SUM_LIMIT_NEG = -SUM_LIMIT;

    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    // quadrant of the azimuth code (top two bits)
    localparam logic [1:0] QUAD_0_90    = 2'd0;
    localparam logic [1:0] QUAD_90_180  = 2'd1;
    localparam logic [1:0] QUAD_180_270 = 2'd2;
    localparam logic [1:0] QUAD_270_360 = 2'd3;

    // one classified cluster: et (zero for an empty marker), trig magnitudes and signs, last flag
    typedef struct packed {
        logic [ET_BITS-1:0] et;
        logic [TRIG_W-1:0]  cos_mag;
        logic [TRIG_W-1:0]  sin_mag;
        logic               cos_neg;
        logic               sin_neg;
        logic               last;
    } t_work;

    typedef logic [TRIG_W-1:0] t_trig_tab [0:QTR];

    // taylor term divisors (2n)(2n+1)
    function automatic logic [63:0] taylor_div(input int n, input logic [63:0] v);
        logic [63:0] res;
        unique case (n)
            1:       res = v / 64'd6;
            2:       res = v / 64'd20;
            3:       res = v / 64'd42;
            4:       res = v / 64'd72;
            5:       res = v / 64'd110;
            6:       res = v / 64'd156;
            7:       res = v / 64'd210;
            8:       res = v / 64'd272;
            9:       res = v / 64'd342;
            10:      res = v / 64'd420;
            11:      res = v / 64'd506;
            default: res = v / 64'd600;
        endcase
        return res;
    endfunction

    // sin(pi/2 * j/QTR) in q1.14 from a q2.30 series
    function automatic logic [TRIG_W-1:0] quarter_sine(input int j);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] r;
        longint      s;
        if (j >= QTR) begin
            return TRIG_W'(TRIG_ONE);
        end
        x    = (64'(j) * HALF_PI_Q30) / 64'(QTR);
        x2   = (x * x) >> 30;
        term = x;
        s    = longint'(x);
        for (int n = 1; n <= 12; n++) begin
            term = taylor_div(n, (term * x2) >> 30);
            if ((n % 2) == 1) begin
                s = s - longint'(term);
            end else begin
                s = s + longint'(term);
            end
        end
        if (s < 0) begin
            s = 0;
        end
        r = (64'(s) + 64'h8000) >> 16;
        if (r > 64'(TRIG_ONE)) begin
            r = 64'(TRIG_ONE);
        end
        return r[TRIG_W-1:0];
    endfunction

    function automatic t_trig_tab build_sin_tab();
        t_trig_tab t;
        for (int k = 0; k <= QTR; k++) begin
            t[k] = quarter_sine(k);
        end
        return t;
    endfunction

    localparam t_trig_tab SIN_TAB = build_sin_tab();

endpackage

// ===== sv/mets_front.sv =====
// front stage: takes clusters, looks up cosine and sine, hands classified work to the queue
module mets_front
    import mets_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [IN_ET_W-1:0]  i_cluster_et,
    input  logic [IN_PHI_W-1:0] i_cluster_phi,
    input  logic                i_cluster_present,
    input  logic                i_last_cluster,
    output logic                o_work_valid,
    output t_work               o_work,
    input  logic                i_q_full
);

    logic               r_valid;
    t_work              r_work;
    t_work              n_work;
    logic               w_take;
    logic               w_push;
    logic [PHI_BITS-1:0] w_phi;
    logic [1:0]         w_quad;
    logic [TAB_AW-1:0]  w_j;
    logic [TRIG_W-1:0]  w_a;
    logic [TRIG_W-1:0]  w_b;

    assign o_in_stall   = r_valid && i_q_full;
    assign w_take       = i_in_valid && !o_in_stall;
    assign w_push       = r_valid && !i_q_full;
    assign o_work_valid = r_valid;
    assign o_work       = r_work;

    assign w_phi  = i_cluster_phi[PHI_BITS-1:0];
    assign w_quad = w_phi[PHI_BITS-1 -: 2];
    assign w_j    = {1'b0, w_phi[J_W-1:0]};
    assign w_a    = SIN_TAB[w_j];
    assign w_b    = SIN_TAB[TAB_AW'(QTR) - w_j];

    always_comb begin
        // an empty marker carries zero et, so it adds nothing downstream
        n_work.et   = i_cluster_present ? i_cluster_et[ET_BITS-1:0] : '0;
        n_work.last = i_last_cluster;
        unique case (w_quad)
            QUAD_0_90: begin
                n_work.cos_mag = w_b; n_work.cos_neg = 1'b0;
                n_work.sin_mag = w_a; n_work.sin_neg = 1'b0;
            end
            QUAD_90_180: begin
                n_work.cos_mag = w_a; n_work.cos_neg = 1'b1;
                n_work.sin_mag = w_b; n_work.sin_neg = 1'b0;
            end
            QUAD_180_270: begin
                n_work.cos_mag = w_b; n_work.cos_neg = 1'b1;
                n_work.sin_mag = w_a; n_work.sin_neg = 1'b1;
            end
            QUAD_270_360: begin
                n_work.cos_mag = w_a; n_work.cos_neg = 1'b0;
                n_work.sin_mag = w_b; n_work.sin_neg = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (w_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_work <= n_work;
        end
    end

endmodule

// ===== sv/mets_queue.sv =====
// short fifo of classified work between the front and back stages
module mets_queue
    import mets_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_work i_push_data,
    output logic  o_full,
    output logic  o_valid,
    output t_work o_data,
    input  logic  i_pop
);

    t_work          r_mem [0:QDEPTH-1];
    logic [QAW-1:0] r_wr_ptr;
    logic [QAW-1:0] r_rd_ptr;
    logic [QAW:0]   r_count;
    logic           w_wr;
    logic           w_rd;

    assign o_full  = (r_count == (QAW+1)'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

// ===== sv/mets_back.sv =====
// back stage: scales et by the trig values, accumulates saturating sums, emits on last
module mets_back
    import mets_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_work_valid,
    input  t_work               i_work,
    output logic                o_work_pop,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [EX_W-1:0]     o_missing_ex,
    output logic [EX_W-1:0]     o_missing_ey,
    output logic [ET_OUT_W-1:0] o_scalar_et,
    output logic                o_sum_overflow
);

    // product stage
    logic               r_m_valid;
    logic [MAG_W-1:0]   r_m_x_mag;
    logic [MAG_W-1:0]   r_m_y_mag;
    logic               r_m_cos_neg;
    logic               r_m_sin_neg;
    logic [ET_BITS-1:0] r_m_et;
    logic               r_m_last;
    logic [PROD_W-1:0]  w_px;
    logic [PROD_W-1:0]  w_py;

    // running sums
    logic signed [SUM_W-1:0] r_ex_sum;
    logic signed [SUM_W-1:0] r_ey_sum;
    logic [ET_SUM_W-1:0]     r_et_sum;
    logic                    r_ovf;
    logic signed [SUM_W-1:0] n_ex_raw;
    logic signed [SUM_W-1:0] n_ey_raw;
    logic signed [SUM_W-1:0] n_ex;
    logic signed [SUM_W-1:0] n_ey;
    logic [ET_SUM_W-1:0]     n_et_raw;
    logic [ET_SUM_W-1:0]     n_et;
    logic                    n_ovf;
    logic signed [SUM_W-1:0] w_x_term;
    logic signed [SUM_W-1:0] w_y_term;

    // output register
    logic                r_o_valid;
    logic [EX_W-1:0]     r_o_ex;
    logic [EX_W-1:0]     r_o_ey;
    logic [ET_OUT_W-1:0] r_o_et;
    logic                r_o_ovf;

    logic w_out_free;
    logic w_consume;
    logic w_load;

    assign w_out_free = !r_o_valid || !i_out_stall;
    // only a closing item has to wait for the output register
    assign w_consume  = r_m_valid && (!r_m_last || w_out_free);
    assign w_load     = i_work_valid && (!r_m_valid || w_consume);
    assign o_work_pop = w_load;

    assign w_px = PROD_W'(i_work.et) * PROD_W'(i_work.cos_mag);
    assign w_py = PROD_W'(i_work.et) * PROD_W'(i_work.sin_mag);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_load) begin
            r_m_valid <= 1'b1;
        end else if (w_consume) begin
            r_m_valid <= 1'b0;
        end
    end

    // round to nearest on magnitudes, ties away from zero
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_m_x_mag   <= MAG_W'((w_px + PROD_W'(1 << (FRAC_W - 1))) >> FRAC_W);
            r_m_y_mag   <= MAG_W'((w_py + PROD_W'(1 << (FRAC_W - 1))) >> FRAC_W);
            r_m_cos_neg <= i_work.cos_neg;
            r_m_sin_neg <= i_work.sin_neg;
            r_m_et      <= i_work.et;
            r_m_last    <= i_work.last;
        end
    end

    assign w_x_term = signed'(SUM_W'(r_m_x_mag));
    assign w_y_term = signed'(SUM_W'(r_m_y_mag));

    always_comb begin
        n_ovf    = r_ovf;
        // the missing components take the negated projections
        n_ex_raw = r_m_cos_neg ? (r_ex_sum + w_x_term) : (r_ex_sum - w_x_term);
        n_ey_raw = r_m_sin_neg ? (r_ey_sum + w_y_term) : (r_ey_sum - w_y_term);
        n_et_raw = r_et_sum + ET_SUM_W'(r_m_et);
        priority if (n_ex_raw > SUM_LIMIT) begin
            n_ex  = SUM_LIMIT;
            n_ovf = 1'b1;
        end else if (n_ex_raw < SUM_LIMIT_NEG) begin
            n_ex  = SUM_LIMIT_NEG;
            n_ovf = 1'b1;
        end else begin
            n_ex = n_ex_raw;
        end
        priority if (n_ey_raw > SUM_LIMIT) begin
            n_ey  = SUM_LIMIT;
            n_ovf = 1'b1;
        end else if (n_ey_raw < SUM_LIMIT_NEG) begin
            n_ey  = SUM_LIMIT_NEG;
            n_ovf = 1'b1;
        end else begin
            n_ey = n_ey_raw;
        end
        if (n_et_raw > ET_SUM_W'(SUM_LIMIT)) begin
            n_et  = ET_SUM_W'(SUM_LIMIT);
            n_ovf = 1'b1;
        end else begin
            n_et = n_et_raw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ex_sum <= '0;
            r_ey_sum <= '0;
            r_et_sum <= '0;
            r_ovf    <= 1'b0;
        end else if (w_consume) begin
            if (r_m_last) begin
                r_ex_sum <= '0;
                r_ey_sum <= '0;
                r_et_sum <= '0;
                r_ovf    <= 1'b0;
            end else begin
                r_ex_sum <= n_ex;
                r_ey_sum <= n_ey;
                r_et_sum <= n_et;
                r_ovf    <= n_ovf;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_consume && r_m_last) begin
            r_o_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_consume && r_m_last) begin
            r_o_ex  <= n_ex[EX_W-1:0];
            r_o_ey  <= n_ey[EX_W-1:0];
            r_o_et  <= n_et[ET_OUT_W-1:0];
            r_o_ovf <= n_ovf;
        end
    end

    assign o_out_valid    = r_o_valid;
    assign o_missing_ex   = r_o_ex;
    assign o_missing_ey   = r_o_ey;
    assign o_scalar_et    = r_o_et;
    assign o_sum_overflow = r_o_ovf;

endmodule

// ===== sv/missing_et_vector_sum_core.sv =====
// top level of the missing transverse energy vector sum
//
// input channel: one calorimeter cluster per transfer (et, phi code, present flag,
// last flag), moved when i_in_valid is high and o_in_stall is low.
// output channel: one result per event (missing ex, missing ey, scalar et, overflow),
// moved when o_out_valid is high and i_out_stall is low; it appears only for a
// cluster marked last, and an empty marker with last closes an event adding nothing to it.
// throughput: one cluster per clock while no closing cluster waits on a held result,
// set by the saturating accumulate in the back stage.
// path: a closing cluster's result reaches the outputs through the front register,
// the queue write, the multiply stage and the sum into the output register.
// a stalled result holds in the output register; clusters that do not close an
// event keep flowing into the sums meanwhile, and a four-entry queue plus the
// front register absorb further clusters before o_in_stall rises.
// reset (synchronous, active low) clears the sums, the overflow flag, the queue
// and all valid flags; no clearing pass is needed.
module missing_et_vector_sum_core
    import mets_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [IN_ET_W-1:0]  i_cluster_et,
    input  logic [IN_PHI_W-1:0] i_cluster_phi,
    input  logic                i_cluster_present,
    input  logic                i_last_cluster,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [EX_W-1:0]     o_missing_ex,
    output logic [EX_W-1:0]     o_missing_ey,
    output logic [ET_OUT_W-1:0] o_scalar_et,
    output logic                o_sum_overflow
);

    logic  w_f_valid;
    t_work w_f_work;
    logic  w_q_full;
    logic  w_q_valid;
    t_work w_q_data;
    logic  w_q_pop;

    mets_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_cluster_et      (i_cluster_et),
        .i_cluster_phi     (i_cluster_phi),
        .i_cluster_present (i_cluster_present),
        .i_last_cluster    (i_last_cluster),
        .o_work_valid      (w_f_valid),
        .o_work            (w_f_work),
        .i_q_full          (w_q_full)
    );

    mets_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_f_valid),
        .i_push_data (w_f_work),
        .o_full      (w_q_full),
        .o_valid     (w_q_valid),
        .o_data      (w_q_data),
        .i_pop       (w_q_pop)
    );

    mets_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_work_valid   (w_q_valid),
        .i_work         (w_q_data),
        .o_work_pop     (w_q_pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_missing_ex   (o_missing_ex),
        .o_missing_ey   (o_missing_ey),
        .o_scalar_et    (o_scalar_et),
        .o_sum_overflow (o_sum_overflow)
    );

    // the queue is never both full and empty
    a_queue_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_q_full && !w_q_valid))
        else $error("queue reports full while empty");

    // the front only stalls when the queue cannot take its held cluster
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (w_f_valid && w_q_full))
        else $error("input stalled without a full queue");

    // a result always stays within the saturation limits
    a_result_limits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((SUM_W'(o_scalar_et) <= SUM_LIMIT)
            && (signed'(o_missing_ex) <= SUM_LIMIT)
            && (signed'(o_missing_ex) >= SUM_LIMIT_NEG)
            && (signed'(o_missing_ey) <= SUM_LIMIT)
            && (signed'(o_missing_ey) >= SUM_LIMIT_NEG)))
        else $error("result outside saturation limits");

endmodule

// ===== test/tb_missing_et_vector_sum_core.sv =====
// testbench for the missing et vector sum core: predicted event sums checked against results
module tb_missing_et_vector_sum_core
    import mets_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    typedef longint unsigned t_u64;

    localparam int     IDLE_LIMIT         = 3000;
    localparam int     HOLD_OFF_CYCLES    = 120;
    localparam int     DRAIN_CYCLES       = 20;
    localparam int     RANDOM_ITEMS       = 400;
    localparam int     SAT_EVENT_CLUSTERS = 1500;
    localparam t_u64   HALF_PI_Q2_30      = 64'd1686629713;
    localparam longint SAT_LIMIT = longint'(MAX_CLUSTERS) * ((longint'(1) << ET_BITS) - 1);

    typedef enum {ET_FULL, ET_LOW, ET_HIGH, ET_EDGE} t_et_style;
    typedef enum {STALL_NONE, STALL_HALF, STALL_HEAVY, STALL_PERIODIC} t_stall_mode;

    typedef struct packed {
        logic [EX_W-1:0]     ex;
        logic [EX_W-1:0]     ey;
        logic [ET_OUT_W-1:0] et;
        logic                ovf;
    } t_met_result;

    class t_met_sum_tracker;
        int          sine_q14 [0:QTR];
        longint      acc_x;
        longint      acc_y;
        longint      acc_et;
        bit          acc_ovf;
        t_met_result pending_met[$];
        int          mismatches;

        function new();
            for (int k = 0; k <= QTR; k++) begin
                sine_q14[k] = series_sine(k);
            end
            acc_x      = 0;
            acc_y      = 0;
            acc_et     = 0;
            acc_ovf    = 0;
            mismatches = 0;
        endfunction

        // q1.14 sine of a quarter-wave step from a truncated q2.30 taylor series
        static function int series_sine(int j);
            t_u64   x;
            t_u64   x2;
            t_u64   term;
            t_u64   r;
            longint s;
            if (j >= QTR) begin
                return TRIG_ONE;
            end
            x    = (t_u64'(j) * HALF_PI_Q2_30) / t_u64'(QTR);
            x2   = (x * x) >> 30;
            term = x;
            s    = longint'(x);
            for (int n = 1; n <= 12; n++) begin
                term = ((term * x2) >> 30) / t_u64'((2 * n) * (2 * n + 1));
                if ((n % 2) == 1) begin
                    s = s - longint'(term);
                end else begin
                    s = s + longint'(term);
                end
            end
            if (s < 0) begin
                s = 0;
            end
            r = (t_u64'(s) + 64'd32768) >> 16;
            if (r > t_u64'(TRIG_ONE)) begin
                r = t_u64'(TRIG_ONE);
            end
            return int'(r);
        endfunction

        // et times q1.14 trig, rounded to nearest with ties away from zero
        static function longint rounded_product(longint et, longint trig);
            longint p;
            longint mag;
            longint r;
            p   = et * trig;
            mag = (p < 0) ? -p : p;
            r   = (mag + 8192) >>> 14;
            return (p < 0) ? -r : r;
        endfunction

        function longint clamp_sum(longint v);
            if (v > SAT_LIMIT) begin
                acc_ovf = 1;
                return SAT_LIMIT;
            end
            if (v < -SAT_LIMIT) begin
                acc_ovf = 1;
                return -SAT_LIMIT;
            end
            return v;
        endfunction

        function void take_cluster(logic [IN_ET_W-1:0] et_in, logic [IN_PHI_W-1:0] phi_in,
                                   logic present, logic last);
            longint      et;
            longint      a;
            longint      b;
            longint      c;
            longint      s;
            int          phi;
            int          j;
            t_met_result r;
            et  = longint'(et_in) & ((longint'(1) << ET_BITS) - 1);
            phi = int'(phi_in) & ((1 << PHI_BITS) - 1);
            j   = phi & (QTR - 1);
            if (present) begin
                a = sine_q14[j];
                b = sine_q14[QTR - j];
                case (phi >> (PHI_BITS - 2))
                    QUAD_0_90: begin
                        c = b;
                        s = a;
                    end
                    QUAD_90_180: begin
                        c = -a;
                        s = b;
                    end
                    QUAD_180_270: begin
                        c = -b;
                        s = -a;
                    end
                    default: begin
                        c = a;
                        s = -b;
                    end
                endcase
                acc_x  = clamp_sum(acc_x - rounded_product(et, c));
                acc_y  = clamp_sum(acc_y - rounded_product(et, s));
                acc_et = acc_et + et;
                if (acc_et > SAT_LIMIT) begin
                    acc_et  = SAT_LIMIT;
                    acc_ovf = 1;
                end
            end
            if (last) begin
                r.ex  = EX_W'(acc_x);
                r.ey  = EX_W'(acc_y);
                r.et  = ET_OUT_W'(acc_et);
                r.ovf = acc_ovf;
                pending_met.push_back(r);
                acc_x   = 0;
                acc_y   = 0;
                acc_et  = 0;
                acc_ovf = 0;
            end
        endfunction

        task report_mismatch(string what);
            $display("mismatch at %0t ns: %s", $realtime, what);
            mismatches++;
        endtask

        task compare_field(string name, logic [EX_W-1:0] got, logic [EX_W-1:0] want);
            if (got !== want) begin
                report_mismatch($sformatf("%s got %h expected %h", name, got, want));
            end
        endtask

        task check_met(t_met_result got);
            t_met_result want;
            if (pending_met.size() == 0) begin
                report_mismatch("result transfer with no closed event pending");
                return;
            end
            want = pending_met.pop_front();
            compare_field("missing_ex", got.ex, want.ex);
            compare_field("missing_ey", got.ey, want.ey);
            compare_field("scalar_et", EX_W'(got.et), EX_W'(want.et));
            compare_field("sum_overflow", EX_W'(got.ovf), EX_W'(want.ovf));
        endtask
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    logic [IN_ET_W-1:0]  i_cluster_et;
    logic [IN_PHI_W-1:0] i_cluster_phi;
    logic                i_cluster_present;
    logic                i_last_cluster;
    logic                o_out_valid;
    logic                i_out_stall;
    logic [EX_W-1:0]     o_missing_ex;
    logic [EX_W-1:0]     o_missing_ey;
    logic [ET_OUT_W-1:0] o_scalar_et;
    logic                o_sum_overflow;

    t_met_sum_tracker tracker = new();

    bit hold_off_req;
    bit steady_sender;
    int burst_left;
    int idle_cycles;

    missing_et_vector_sum_core dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_cluster_et      (i_cluster_et),
        .i_cluster_phi     (i_cluster_phi),
        .i_cluster_present (i_cluster_present),
        .i_last_cluster    (i_last_cluster),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_missing_ex      (o_missing_ex),
        .o_missing_ey      (o_missing_ey),
        .o_scalar_et       (o_scalar_et),
        .o_sum_overflow    (o_sum_overflow)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // result checking and the watchdog on stalled progress
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                tracker.check_met({o_missing_ex, o_missing_ey, o_scalar_et, o_sum_overflow});
            end
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb_missing_et_vector_sum_core NOT OK");
                $finish;
            end
        end
    end

    // result side: stall pattern that changes mode now and then, plus requested hold-offs
    initial begin
        t_stall_mode mode;
        int          mode_left;
        int          hold_left;
        int          phase;
        i_out_stall = 1'b0;
        mode        = STALL_NONE;
        mode_left   = 0;
        hold_left   = 0;
        phase       = 0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                hold_left    = HOLD_OFF_CYCLES;
                hold_off_req = 1'b0;
            end
            if (hold_left > 0) begin
                i_out_stall = 1'b1;
                hold_left--;
            end else begin
                if (mode_left == 0) begin
                    mode      = t_stall_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(20, 150);
                end
                mode_left--;
                phase = (phase + 1) % 7;
                case (mode)
                    STALL_NONE:  i_out_stall = 1'b0;
                    STALL_HALF:  i_out_stall = 1'($urandom_range(0, 1));
                    STALL_HEAVY: i_out_stall = ($urandom_range(0, 4) != 0);
                    default:     i_out_stall = (phase < 3);
                endcase
            end
        end
    end

    // one cluster transfer, then a random gap when the current burst runs out (not for a steady sender)
    task automatic offer_cluster(input logic [IN_ET_W-1:0] et, input logic [IN_PHI_W-1:0] phi,
                                 input logic present, input logic last);
        @(negedge i_clk);
        i_in_valid        = 1'b1;
        i_cluster_et      = et;
        i_cluster_phi     = phi;
        i_cluster_present = present;
        i_last_cluster    = last;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        tracker.take_cluster(et, phi, present, last);
        if (!steady_sender) begin
            burst_left--;
            if (burst_left <= 0) begin
                repeat ($urandom_range(1, 8)) begin
                    @(negedge i_clk);
                    i_in_valid        = 1'b0;
                    i_cluster_et      = IN_ET_W'($urandom);
                    i_cluster_phi     = IN_PHI_W'($urandom);
                    i_cluster_present = 1'($urandom_range(0, 1));
                    i_last_cluster    = 1'($urandom_range(0, 1));
                end
                burst_left = $urandom_range(1, 40);
            end
        end
    endtask

    // hold the input idle until every closed event has been delivered
    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (tracker.pending_met.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic send_random_event(input int n_clusters);
        t_et_style          style;
        logic [IN_ET_W-1:0] et;
        logic               present;
        style = t_et_style'($urandom_range(0, 3));
        for (int k = 0; k < n_clusters; k++) begin
            case (style)
                ET_FULL: et = IN_ET_W'($urandom);
                ET_LOW:  et = IN_ET_W'($urandom_range(0, 255));
                ET_HIGH: et = IN_ET_W'($urandom_range(65000, 65535));
                default: et = $urandom_range(0, 1) ? {IN_ET_W{1'b1}} : IN_ET_W'($urandom_range(0, 3));
            endcase
            present = ($urandom_range(0, 9) != 0);
            offer_cluster(et, IN_PHI_W'($urandom), present, k == n_clusters - 1);
        end
    endtask

    // long event at full et in one direction, then a few clusters pulling back
    task automatic send_saturating_event(input logic [IN_PHI_W-1:0] phi_main,
                                         input logic [IN_PHI_W-1:0] phi_back);
        for (int k = 0; k < SAT_EVENT_CLUSTERS; k++) begin
            offer_cluster({IN_ET_W{1'b1}}, phi_main, 1'b1, 1'b0);
        end
        for (int k = 0; k < 6; k++) begin
            offer_cluster(IN_ET_W'($urandom), phi_back, 1'b1, k == 5);
        end
    endtask

    initial begin
        int random_items;
        int n_clusters;
        bit hold_done;
        bit drain_done;
        i_rst_n           = 1'b0;
        i_in_valid        = 1'b0;
        i_cluster_et      = '0;
        i_cluster_phi     = '0;
        i_cluster_present = 1'b0;
        i_last_cluster    = 1'b0;
        hold_off_req      = 1'b0;
        steady_sender     = 1'b0;
        burst_left        = 1;
        random_items      = 0;
        hold_done         = 1'b0;
        drain_done        = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // field extremes, quadrant boundaries, empty events and markers
        offer_cluster(16'hFFFF, 10'd0, 1'b1, 1'b1);
        offer_cluster(16'h0000, 10'd1023, 1'b1, 1'b1);
        offer_cluster(16'h0000, 10'd0, 1'b0, 1'b1);
        offer_cluster(16'd1234, 10'd255, 1'b1, 1'b0);
        offer_cluster(16'hFFFF, 10'd256, 1'b1, 1'b0);
        offer_cluster(16'd777, 10'd511, 1'b0, 1'b0);
        offer_cluster(16'hFFFF, 10'd512, 1'b1, 1'b0);
        offer_cluster(16'd40000, 10'd767, 1'b1, 1'b1);
        offer_cluster(16'hFFFF, 10'd768, 1'b1, 1'b0);
        offer_cluster(16'hFFFF, 10'd1023, 1'b1, 1'b0);
        offer_cluster(16'd1, 10'd128, 1'b1, 1'b0);
        offer_cluster(16'd1, 10'd384, 1'b1, 1'b0);
        offer_cluster(16'd3, 10'd640, 1'b1, 1'b0);
        offer_cluster(16'd5, 10'd896, 1'b1, 1'b1);
        offer_cluster(16'd43690, 10'd341, 1'b1, 1'b0);
        offer_cluster(16'd21845, 10'd682, 1'b1, 1'b0);
        offer_cluster(16'h0000, 10'd0, 1'b0, 1'b1);
        offer_cluster(16'hFFFF, 10'd1023, 1'b0, 1'b1);
        offer_cluster(16'h8000, 10'h200, 1'b1, 1'b1);

        // saturation of the missing sums in both directions and of the scalar et sum
        send_saturating_event(10'd128, 10'd640);
        send_saturating_event(10'd640, 10'd128);
        drain_results();

        while (random_items < RANDOM_ITEMS) begin
            if (!hold_done && random_items > RANDOM_ITEMS / 3) begin
                // results held back while single-cluster events keep coming
                hold_done     = 1'b1;
                steady_sender = 1'b1;
                hold_off_req  = 1'b1;
                repeat (40) offer_cluster(IN_ET_W'($urandom), IN_PHI_W'($urandom), 1'b1, 1'b1);
                steady_sender = 1'b0;
            end
            if (!drain_done && random_items > (3 * RANDOM_ITEMS) / 4) begin
                drain_done = 1'b1;
                drain_results();
            end
            n_clusters = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 60)
                                                     : $urandom_range(1, 8);
            send_random_event(n_clusters);
            random_items += n_clusters;
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tracker.mismatches == 0 && tracker.pending_met.size() == 0) begin
            $display("tb_missing_et_vector_sum_core OK");
        end else begin
            $display("tb_missing_et_vector_sum_core NOT OK");
        end
        $finish;
    end

endmodule

// ===== missing_et_vector_sum_core.f =====
sv/mets_pkg.sv
sv/mets_front.sv
sv/mets_queue.sv
sv/mets_back.sv
sv/missing_et_vector_sum_core.sv
test/tb_missing_et_vector_sum_core.sv
